// ===== design/bbr_pkg.sv =====
// shared types and constants of the 3x3 rgb box blur
`default_nettype none

package bbr_pkg;

  // configuration register map
  localparam int unsigned CFG_DW = 11;
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic [CFG_DW-1:0] FRAME_WIDTH_RST  = 11'd800;
  localparam logic [CFG_DW-1:0] FRAME_HEIGHT_RST = 11'd600;

  localparam logic [7:0] ALPHA = 8'hFF;

  // floor(s / 9) = (s * 7282) >> 16, exact for s below 9 * 3640
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one classified item from the front to the back
  typedef struct packed {
    rgb_t       pix;
    logic       emit;
    logic       top_en;
    logic       bot_en;
    logic       left_en;
    logic       right_en;
    logic       frame_end;
    logic [9:0] x;
    logic [9:0] y;
  } cmd_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    rgb_t       rgb;
    logic       frame_end;
  } res_t;

endpackage

`default_nettype wire

// ===== design/bbr_fifo.sv =====
// small register queue used between the blur stages
`default_nettype none

module bbr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== design/bbr_front.sv =====
// stream position tracking and item classification
`default_nettype none

module bbr_front import bbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic [CFG_DW-1:0]            frame_width_i,
  input  logic [CFG_DW-1:0]            frame_height_i,
  input  logic                         valid_i,
  input  logic                         func_i,
  input  rgb_t                         rgb_i,
  output cmd_t                         cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned EW    = (WW > CFG_DW) ? WW : CFG_DW;
  localparam int unsigned EH    = (HW > CFG_DW) ? HW : CFG_DW;

  logic [COL_W-1:0] col_q, col_d, col_c, ox;
  logic [ROW_W-1:0] row_q, row_d, row_c, oy, h_row, h_p1;
  logic [EW-1:0]    w_raw;
  logic [EH-1:0]    h_raw;
  logic [WW-1:0]    w_eff, col_inc;
  logic [HW-1:0]    h_eff;
  logic             wrap, emit_a, emit_b, emit, frame_end;

  // out-of-range sizes clamp to 1 and to the maximum
  assign w_raw = EW'(frame_width_i);
  assign h_raw = EH'(frame_height_i);
  assign w_eff = (w_raw == '0) ? WW'(1) :
                 (w_raw > EW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_raw);
  assign h_eff = (h_raw == '0) ? HW'(1) :
                 (h_raw > EH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_raw);
  assign h_row = ROW_W'(h_eff);
  assign h_p1  = h_row + ROW_W'(1);

  always_comb begin
    wrap  = (WW'(col_q) >= w_eff) || (row_q > h_p1);
    col_c = wrap ? '0 : col_q;
    row_c = wrap ? '0 : row_q;

    // last column of a row is finished when the next row starts
    emit_a = (col_c == '0) && (row_c >= ROW_W'(2));
    emit_b = (col_c != '0) && (row_c != '0) && (row_c <= h_row);
    emit   = emit_a || emit_b;

    ox = emit_a ? COL_W'(w_eff - WW'(1)) : col_c - COL_W'(1);
    oy = emit_a ? row_c - ROW_W'(2) : row_c - ROW_W'(1);

    frame_end = (WW'(ox) == w_eff - WW'(1)) && (oy == h_row - ROW_W'(1));

    cmd_o.pix       = (!func_i && (row_c < h_row)) ? rgb_i : '0;
    cmd_o.emit      = emit;
    cmd_o.top_en    = (oy != '0);
    cmd_o.bot_en    = (oy + ROW_W'(1)) < h_row;
    cmd_o.left_en   = (ox != '0);
    cmd_o.right_en  = (WW'(ox) + WW'(1)) < w_eff;
    cmd_o.frame_end = frame_end;
    cmd_o.x         = 10'(ox);
    cmd_o.y         = 10'(oy);
    col_o           = col_c;

    col_inc = WW'(col_c) + WW'(1);
    if (emit && frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = row_c + ROW_W'(1);
    end else begin
      col_d = COL_W'(col_inc);
      row_d = row_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (valid_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bbr_back.sv =====
// line buffers, 3x3 window, channel sums and divide by nine
`default_nettype none

module bbr_back import bbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_empty_i,
  input  cmd_t                                cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        col_i,
  output logic                                cmd_pop_o,
  input  logic [$clog2(RES_DEPTH+1)-1:0]      res_count_i,
  output logic                                res_push_o,
  output res_t                                res_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned RCW   = $clog2(RES_DEPTH + 1);
  localparam int unsigned PW    = SUM_W + RECIP_W;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_t;

  line_t line_mem [MAX_WIDTH];

  // read stage
  logic             s1_valid_q;
  cmd_t             s1_cmd_q;
  logic [COL_W-1:0] s1_col_q;
  line_t            rd_q;
  logic             byp_q, byp_d;
  line_t            byp_data_q;

  // sum stage
  logic             s2_valid_q;
  logic             s2_emit_q;
  logic [9:0]       s2_x_q, s2_y_q;
  logic             s2_end_q;
  logic [SUM_W-1:0] s2_sum_r_q, s2_sum_g_q, s2_sum_b_q;

  logic             issue, credit_ok;
  logic [1:0]       inflight;
  line_t            line_rd, wr_data;
  rgb_t             win_q [9];
  rgb_t             win_d [9];
  logic [2:0]       row_en, col_en;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [PW-1:0]    prod_r, prod_g, prod_b;

  // only issue when the result queue has room for everything in flight
  assign inflight  = {1'b0, s1_valid_q && s1_cmd_q.emit} + {1'b0, s2_valid_q && s2_emit_q};
  assign credit_ok = ((RCW+1)'(res_count_i) + (RCW+1)'(inflight)) < (RCW+1)'(RES_DEPTH);
  assign issue     = !cmd_empty_i && credit_ok;
  assign cmd_pop_o = issue;

  // same column written back by the previous item in this cycle
  assign byp_d = issue && s1_valid_q && (col_i == s1_col_q);

  always_comb begin
    line_rd        = byp_q ? byp_data_q : rd_q;
    wr_data.upper  = line_rd.middle;
    wr_data.middle = s1_cmd_q.pix;

    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = line_rd.upper;
    win_d[5] = line_rd.middle;
    win_d[8] = s1_cmd_q.pix;

    row_en = {s1_cmd_q.bot_en, 1'b1, s1_cmd_q.top_en};
    col_en = {s1_cmd_q.right_en, 1'b1, s1_cmd_q.left_en};

    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (row_en[r] && col_en[k]) begin
          sum_r = sum_r + SUM_W'(win_d[r*3 + k].red);
          sum_g = sum_g + SUM_W'(win_d[r*3 + k].green);
          sum_b = sum_b + SUM_W'(win_d[r*3 + k].blue);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= wr_data;
    end
    if (issue) begin
      rd_q <= line_mem[col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_cmd_q   <= cmd_i;
      s1_col_q   <= col_i;
      byp_q      <= byp_d;
      byp_data_q <= wr_data;
    end
    if (s1_valid_q) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
      s2_emit_q  <= s1_cmd_q.emit;
      s2_x_q     <= s1_cmd_q.x;
      s2_y_q     <= s1_cmd_q.y;
      s2_end_q   <= s1_cmd_q.frame_end;
      s2_sum_r_q <= sum_r;
      s2_sum_g_q <= sum_g;
      s2_sum_b_q <= sum_b;
    end
  end

  // divide by nine through the reciprocal
  assign prod_r = PW'(s2_sum_r_q) * PW'(RECIP9);
  assign prod_g = PW'(s2_sum_g_q) * PW'(RECIP9);
  assign prod_b = PW'(s2_sum_b_q) * PW'(RECIP9);

  assign res_push_o      = s2_valid_q && s2_emit_q;
  assign res_o.x         = s2_x_q;
  assign res_o.y         = s2_y_q;
  assign res_o.rgb.red   = prod_r[RECIP_SHIFT +: 8];
  assign res_o.rgb.green = prod_g[RECIP_SHIFT +: 8];
  assign res_o.rgb.blue  = prod_b[RECIP_SHIFT +: 8];
  assign res_o.frame_end = s2_end_q;

endmodule

`default_nettype wire

// ===== design/box_blur_3x3_rgb.sv =====
// top level of the streaming 3x3 rgb box blur
// throughput: one item per cycle while the result queue has room, limited by the single line buffer read per item
// path: a taken item passes the read and sum stage registers and then the result queue before its result is visible
// a result leaves one row plus one pixel after its center pixel came in
// reset: control clears at once, no clearing pass; line buffers are left as they are
// since every entry counted in a sum was rewritten earlier in the same frame
`default_nettype none

module box_blur_3x3_rgb import bbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // pixel input queue side
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,

  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  out_x_o,
  output logic [9:0]  out_y_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        frame_end_o,

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMD_W = COL_W + $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic [CFG_DW-1:0] frame_width_q, frame_height_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  logic              in_beat;
  cmd_t              front_cmd, back_cmd;
  logic [COL_W-1:0]  front_col, back_col;
  logic              cmd_pop, cmd_empty;

  logic              res_push;
  res_t              res_in, res_out;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;

  // apb: writes land in the access phase, every write restarts the frame
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_DW-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // front: tracks raster position, decides what each beat produces
  assign in_beat = push && !full;

  bbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (cfg_wr),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .valid_i        (in_beat),
    .func_i         (func_i),
    .rgb_i          ({in_red_i, in_green_i, in_blue_i}),
    .cmd_o          (front_cmd),
    .col_o          (front_col)
  );

  // decoupling queue between classification and the datapath
  bbr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_beat),
    .data_i  ({front_col, front_cmd}),
    .pop_i   (cmd_pop),
    .data_o  ({back_col, back_cmd}),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // back: line buffers, window and arithmetic, never stalls once issued
  bbr_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .col_i       (back_col),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue: absorbs everything the back has in flight
  bbr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign out_x_o     = res_out.x;
  assign out_y_o     = res_out.y;
  assign out_red_o   = res_out.rgb.red;
  assign out_green_o = res_out.rgb.green;
  assign out_blue_o  = res_out.rgb.blue;
  assign out_alpha_o = ALPHA;
  assign frame_end_o = res_out.frame_end;

endmodule

`default_nettype wire

// ===== design/bbr_checker.sv =====
// port-level checks of the box blur, bound to the top level
`default_nettype none

module bbr_checker import bbr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [9:0] out_x_i,
  input logic [9:0] out_y_i,
  input logic [7:0] out_red_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_blue_i,
  input logic [7:0] out_alpha_i,
  input logic       frame_end_i
);

  // a waiting result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before pop");

  // a waiting result does not change
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_x_i) && $stable(out_y_i) && $stable(out_red_i)
      && $stable(out_green_i) && $stable(out_blue_i) && $stable(frame_end_i))
    else $error("waiting result changed");

  // alpha is fixed opaque
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_alpha_i == ALPHA)
    else $error("alpha not opaque");

  // the beat after the end of a frame starts the next frame at the origin
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && frame_end_i |=> empty || (out_x_i == 10'd0 && out_y_i == 10'd0))
    else $error("next frame does not start at origin");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .out_x_i     (out_x_o),
  .out_y_i     (out_y_o),
  .out_red_i   (out_red_o),
  .out_green_i (out_green_o),
  .out_blue_i  (out_blue_o),
  .out_alpha_i (out_alpha_o),
  .frame_end_i (frame_end_o)
);

`default_nettype wire
